/* rtl/cordic_pkg.sv */
// cordic_pkg: shared types and constants for the cordic sine/cosine pipeline
// holds the per-stage word type, the gain, the arctangent table and csr codes
// no dependencies
package cordic_pkg;

   localparam int DATA_W  = 16;
   localparam int STEPS_W = 5;
   localparam int SHIFT_W = 4;

   // cordic gain 0.607252935 in q15
   localparam logic signed [DATA_W-1:0] GAIN_Q15 = 16'sd19898;

   // csr register word index and reset value
   localparam logic REG_ITERATION_COUNT = 1'b0;
   localparam logic [STEPS_W-1:0] ITERATION_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic [STEPS_W-1:0]       steps;
   } cordic_word_type;

   // round(atan(2^-i) * 4096)
   function automatic logic signed [DATA_W-1:0] cordic_atan(input logic [SHIFT_W-1:0] idx);
      logic signed [DATA_W-1:0] val;
      case (idx)
         4'd0:    val = 16'sd3217;
         4'd1:    val = 16'sd1899;
         4'd2:    val = 16'sd1003;
         4'd3:    val = 16'sd509;
         4'd4:    val = 16'sd256;
         4'd5:    val = 16'sd128;
         4'd6:    val = 16'sd64;
         4'd7:    val = 16'sd32;
         4'd8:    val = 16'sd16;
         4'd9:    val = 16'sd8;
         4'd10:   val = 16'sd4;
         4'd11:   val = 16'sd2;
         4'd12:   val = 16'sd1;
         default: val = 16'sd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/cordic_stage.sv */
// cordic_stage: one registered micro-rotation of the cordic pipeline
// a stage with its own valid bit, filling bubbles as the next stage stalls
// depends on cordic_pkg
module cordic_stage import cordic_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_word_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output cordic_word_type out_word
);

   localparam logic [SHIFT_W-1:0] SHIFT     = SHIFT_W'(STAGE);
   localparam logic [STEPS_W-1:0] STAGE_IDX = STEPS_W'(STAGE);
   localparam logic signed [DATA_W-1:0] ATAN = cordic_atan(SHIFT);

   logic            valid_ff;
   logic            valid_in;
   cordic_word_type word_ff;
   cordic_word_type word_in;
   logic signed [DATA_W-1:0] x_shift;
   logic signed [DATA_W-1:0] y_shift;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   assign x_shift = in_word.x >>> SHIFT;
   assign y_shift = in_word.y >>> SHIFT;

   always_comb begin
      word_in = in_word;
      // rotation only while this stage is within the word's step count
      if (in_word.steps > STAGE_IDX) begin
         if (!in_word.z[DATA_W-1]) begin
            word_in.x = in_word.x - y_shift;
            word_in.y = in_word.y + x_shift;
            word_in.z = in_word.z - ATAN;
         end else begin
            word_in.x = in_word.x + y_shift;
            word_in.y = in_word.y - x_shift;
            word_in.z = in_word.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

/* rtl/cordic_sine_cosine.sv */
// cordic_sine_cosine: rotation-mode cordic sine and cosine, one stage per step
// top level with the csr port and the chain of cordic_stage instances
// depends on cordic_pkg and cordic_stage
//
//   channel   dir   handshake            payload
//   req_      in    tvalid/tready        tdata[15:0] angle, q3.12
//   rsp_      out   tvalid/tready        tdata[15:0] cosine, tdata[31:16] sine, q15
//   csr_      in    apb, pready tied 1   iteration_count at byte address 0
//
// one angle per cycle sustained while rsp_ is not stalled; one register stage
// per micro-rotation, the last stage being the output register.
// reset is synchronous, clears all stage valid bits and sets iteration_count
// to 16. a stall at rsp_ holds the last stage; earlier stages keep filling
// bubbles until the whole chain is full, then req_tready drops.
module cordic_sine_cosine import cordic_pkg::*; #(
   parameter int MAX_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [15:0] cosine, [31:16] sine
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [STEPS_W-1:0] iteration_count_ff;
   logic [STEPS_W-1:0] iteration_count_in;
   logic               csr_write;

   logic            valid_chain [MAX_STEPS+1];
   logic            ready_chain [MAX_STEPS+1];
   cordic_word_type word_chain  [MAX_STEPS+1];

   // csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ITERATION_COUNT);
   assign iteration_count_in = csr_write ? csr_pwdata[STEPS_W-1:0] : iteration_count_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ITERATION_COUNT)
                       ? {{(32-STEPS_W){1'b0}}, iteration_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         iteration_count_ff <= ITERATION_COUNT_RESET;
      end else begin
         iteration_count_ff <= iteration_count_in;
      end
   end

   // entry word: x at the gain, y at zero, z at the angle
   assign valid_chain[0]      = req_tvalid;
   assign req_tready          = ready_chain[0];
   assign word_chain[0].x     = GAIN_Q15;
   assign word_chain[0].y     = '0;
   assign word_chain[0].z     = req_tdata;
   assign word_chain[0].steps = iteration_count_ff;

   for (genvar i = 0; i < MAX_STEPS; i++) begin : g_stage
      cordic_stage #(
         .STAGE(i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid_chain[i]),
         .in_ready (ready_chain[i]),
         .in_word  (word_chain[i]),
         .out_valid(valid_chain[i+1]),
         .out_ready(ready_chain[i+1]),
         .out_word (word_chain[i+1])
      );
   end

   assign rsp_tvalid            = valid_chain[MAX_STEPS];
   assign ready_chain[MAX_STEPS] = rsp_tready;
   assign rsp_tdata             = {word_chain[MAX_STEPS].y, word_chain[MAX_STEPS].x};

   // the entry stage can only refuse a word while it holds one
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_chain[1])
      else $error("req_tready low with an empty entry stage");

   // a word with no rotations leaves at the gain with zero sine
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (word_chain[MAX_STEPS].steps == '0)
      |-> (rsp_tdata[15:0] == GAIN_Q15) && (rsp_tdata[31:16] == 16'd0))
      else $error("zero-step word did not pass through unrotated");

   // a register write lands in iteration_count
   assert property (@(posedge clock) disable iff (reset)
      csr_write |=> iteration_count_ff == $past(csr_pwdata[STEPS_W-1:0]))
      else $error("iteration_count write lost");

endmodule

/* sim/cordic_sine_cosine_tb.sv */
// cordic_sine_cosine_tb: self-checking bench for the cordic sine/cosine pipeline
// drives angle words with random gaps and stalls, predicts each cosine/sine pair
// depends on cordic_pkg and cordic_sine_cosine
module cordic_sine_cosine_tb;
   import cordic_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH     = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SINK_HOLD      = 300;
   // angle span where the rotation still converges, about 1.74 rad in q3.12
   localparam int CONVERGE_Q12   = 7127;
   localparam logic [2:0] ITER_COUNT_ADDR = {REG_ITERATION_COUNT, 2'b00};
   // round(atan(2^-i) * 4096), entry 0 in the lowest bits
   localparam logic [16*16-1:0] ATAN_Q12 = {
      16'd0,   16'd0,   16'd0,    16'd1,    16'd2,    16'd4,    16'd8,    16'd16,
      16'd32,  16'd64,  16'd128,  16'd256,  16'd509,  16'd1003, 16'd1899, 16'd3217
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] sine;
      logic signed [DATA_W-1:0] cosine;
   } trig_pair_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;     // [15:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [15:0] cosine, [31:16] sine
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   trig_pair_type      pending_trig[$];
   logic [STEPS_W-1:0] iteration_count_cfg;
   bit                 idle_enabled;
   int                 sink_hold_cycles;
   int                 mismatch_count;
   int                 quiet_cycles;

   cordic_sine_cosine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // micro-rotations on 16-bit wrapping registers, counts above 16 saturate
   function automatic trig_pair_type rotate_angle(input logic signed [DATA_W-1:0] angle,
                                                  input logic [STEPS_W-1:0] count);
      logic signed [DATA_W-1:0] x, y, z, x_shift, y_shift, step_angle;
      int            n, i;
      trig_pair_type pair;
      x = GAIN_Q15;
      y = '0;
      z = angle;
      n = (count > 5'd16) ? 16 : int'(count);
      for (i = 0; i < n; i++) begin
         x_shift    = x >>> i;
         y_shift    = y >>> i;
         step_angle = ATAN_Q12[16*i +: 16];
         if (z >= 0) begin
            x = x - y_shift;
            y = y + x_shift;
            z = z - step_angle;
         end else begin
            x = x + y_shift;
            y = y - x_shift;
            z = z + step_angle;
         end
      end
      pair.cosine = x;
      pair.sine   = y;
      return pair;
   endfunction

   function automatic logic [15:0] random_angle();
      if ($urandom_range(0, 3) != 0)
         return 16'($urandom_range(0, 2 * CONVERGE_Q12) - CONVERGE_Q12);
      return 16'($urandom);
   endfunction

   task automatic send_angle(input logic [15:0] angle);
      int gap;
      gap = idle_enabled ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      do @(posedge clock); while (!req_tready);
      pending_trig.push_back(rotate_angle(angle, iteration_count_cfg));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_trig.size() != 0) @(posedge clock);
   endtask

   task automatic apb_transfer(input bit write_en, input logic [31:0] wdata,
                               output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= ITER_COUNT_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // only called with the pipeline empty
   task automatic set_iteration_count(input logic [STEPS_W-1:0] count);
      logic [31:0] readback;
      wait_drained();
      apb_transfer(1'b1, {27'd0, count}, readback);
      iteration_count_cfg = count;
      apb_transfer(1'b0, 32'd0, readback);
      if (readback !== {27'd0, count}) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("iteration_count readback: expected %0d, got %0d", count, readback);
      end
   endtask

   task automatic test_directed_angles();
      send_angle(16'sd0);
      send_angle(16'sd32767);
      send_angle(-16'sd32768);
      send_angle(16'sd1);
      send_angle(-16'sd1);
      send_angle(16'sd6434);     // +pi/2
      send_angle(-16'sd6434);
      send_angle(16'sd7127);     // edge of convergence
      send_angle(16'sd3217);     // pi/4
      send_angle(16'sd12868);    // pi, outside convergence
      send_angle(-16'sd12868);
   endtask

   // zero count leaves the gain untouched, counts above 16 saturate
   task automatic test_iteration_counts();
      logic [STEPS_W-1:0] counts[6];
      int k;
      counts = '{5'd0, 5'd1, 5'd17, 5'd31, 5'd8, 5'd16};
      for (k = 0; k < 6; k++) begin
         set_iteration_count(counts[k]);
         send_angle(16'sd6434);
         send_angle(-16'sd3217);
      end
   endtask

   task automatic test_backpressure_fill();
      int k;
      idle_enabled     = 1'b0;
      sink_hold_cycles = SINK_HOLD;
      for (k = 0; k < 40; k++)
         send_angle(random_angle());
      idle_enabled = 1'b1;
   endtask

   task automatic test_random_angles();
      int phase, k;
      for (phase = 0; phase < 6; phase++) begin
         set_iteration_count(phase == 0 ? 5'd16 : 5'($urandom_range(0, 31)));
         idle_enabled = (phase % 3 != 2);
         for (k = 0; k < 115; k++)
            send_angle(random_angle());
      end
      idle_enabled = 1'b1;
   endtask

   // result sink: random stall per word, plus one long hold on request
   initial begin : result_sink
      int wait_cycles;
      rsp_tready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            wait_cycles      = sink_hold_cycles;
            sink_hold_cycles = 0;
         end else begin
            wait_cycles = idle_enabled ? $urandom_range(0, 16) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : result_check
      trig_pair_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_trig.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: cosine %0d sine %0d", got.cosine, got.sine);
         end else begin
            want = pending_trig.pop_front();
            if (got.cosine !== want.cosine || got.sine !== want.sine) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: cosine exp %0d got %0d, sine exp %0d got %0d",
                           want.cosine, got.cosine, want.sine, got.sine);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("** cordic_sine_cosine: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_tvalid          = 1'b0;
      req_tdata           = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      iteration_count_cfg = ITERATION_COUNT_RESET;
      idle_enabled        = 1'b1;
      sink_hold_cycles    = 0;
      mismatch_count      = 0;
      quiet_cycles        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_angles();
      test_iteration_counts();
      test_backpressure_fill();
      test_random_angles();

      wait_drained();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_trig.size() == 0) begin
         $display("** cordic_sine_cosine: PASSED **");
      end else begin
         if (pending_trig.size() != 0)
            $display("%0d results never arrived", pending_trig.size());
         $display("** cordic_sine_cosine: FAILED **");
      end
      $finish;
   end

endmodule
